// ----- sv/alist_pkg.sv -----
// Shared types, codes and sizes for the array list engine.
`timescale 1ns / 1ps

package alist_pkg;

  // Store size and derived widths.
  localparam int DEPTH     = 64;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int LEN_W     = $clog2(DEPTH + 1);

  // Fixed field widths of the ports.
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int INDEX_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 6;
  localparam int COUNT_W   = 7;
  localparam int CFG_W     = 7;

  // Widths wide enough to compare an index or a capacity with the length.
  localparam int CMP_W     = (LEN_W > INDEX_W) ? LEN_W : INDEX_W;
  localparam int CAP_W     = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SET    = 3'd2,
    OP_GET    = 3'd3,
    OP_FIND   = 3'd4,
    OP_APPEND = 3'd5,
    OP_CLEAR  = 3'd6
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_STREAM,
    S_FIN
  } state_t;

  typedef struct packed {
    status_t                    status;
    logic signed [DATA_W-1:0]   value;
    logic        [POS_W-1:0]    position;
    logic        [COUNT_W-1:0]  count;
  } result_t;

endpackage

// ----- sv/alist_ram.sv -----
// Entry store: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module alist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/alist_seq.sv -----
// Request sequencer: checks, the entry walk with its shared compare, and the result register.
`timescale 1ns / 1ps

module alist_seq (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [alist_pkg::OP_W-1:0]           opcode,
  input  logic [alist_pkg::INDEX_W-1:0]        index,
  input  logic signed [alist_pkg::DATA_W-1:0]  data,
  input  logic [alist_pkg::LEN_W-1:0]          capacity,
  output logic                                 busy,
  output logic                                 done,
  output alist_pkg::result_t                   result,
  output logic                                 mem_we,
  output logic [alist_pkg::ADDR_W-1:0]         mem_waddr,
  output logic [alist_pkg::DATA_W-1:0]         mem_wdata,
  output logic [alist_pkg::ADDR_W-1:0]         mem_raddr,
  input  logic [alist_pkg::DATA_W-1:0]         mem_rdata
);

  import alist_pkg::*;

  state_t                   state, state_next;
  opcode_t                  op_r;
  logic [INDEX_W-1:0]       idx_r;
  logic signed [DATA_W-1:0] data_r;
  logic [LEN_W-1:0]         len, len_next;
  logic [ADDR_W-1:0]        rd_ptr, last_ptr, st_addr;
  logic                     up, iss, st_valid;
  status_t                  status_r;
  logic signed [DATA_W-1:0] value_r;
  logic [ADDR_W-1:0]        pos_r;

  status_t                  dec_status;
  logic                     go_stream, dec_up;
  logic [ADDR_W-1:0]        dec_first, dec_last;

  logic [CMP_W-1:0]         idx_w, len_w;
  logic [ADDR_W-1:0]        idx_a, lenm1_a;
  logic                     full, hit;

  assign idx_w   = CMP_W'(idx_r);
  assign len_w   = CMP_W'(len);
  assign idx_a   = ADDR_W'(idx_r);
  assign lenm1_a = ADDR_W'(len - 1'b1);
  assign full    = (len >= capacity);

  // The one comparator that the find walk shares over all entries.
  assign hit = (op_r == OP_FIND) && (mem_rdata == data_r);

  assign busy = (state != S_IDLE);

  // Request checks and walk bounds.
  always_comb begin
    dec_status = ST_OK;
    go_stream  = 1'b0;
    dec_up     = 1'b1;
    dec_first  = idx_a;
    dec_last   = idx_a;
    case (op_r)
      OP_INSERT: begin
        if (idx_w > len_w) begin
          dec_status = ST_RANGE;
        end else if (full) begin
          dec_status = ST_FULL;
        end else if (idx_w != len_w) begin
          go_stream = 1'b1;
          dec_up    = 1'b0;
          dec_first = lenm1_a;
        end
      end
      OP_DELETE: begin
        if (idx_w >= len_w) begin
          dec_status = ST_RANGE;
        end else begin
          go_stream = 1'b1;
          dec_last  = lenm1_a;
        end
      end
      OP_SET: begin
        if (idx_w >= len_w) begin
          dec_status = ST_RANGE;
        end
      end
      OP_GET: begin
        if (idx_w >= len_w) begin
          dec_status = ST_RANGE;
        end else begin
          go_stream = 1'b1;
        end
      end
      OP_FIND: begin
        dec_status = ST_NOTFOUND;
        dec_first  = '0;
        dec_last   = lenm1_a;
        go_stream  = (len != '0);
      end
      OP_APPEND: begin
        if (full) begin
          dec_status = ST_FULL;
        end
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = go_stream ? S_STREAM : S_FIN;
      end
      S_STREAM: begin
        if (st_valid && (hit || (st_addr == last_ptr))) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Store port control and the new length.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_a;
    mem_wdata = data_r;
    mem_raddr = rd_ptr;
    len_next  = len;
    unique case (state)
      S_STREAM: begin
        if (st_valid && (op_r == OP_INSERT)) begin
          mem_we    = 1'b1;
          mem_waddr = st_addr + 1'b1;
          mem_wdata = mem_rdata;
        end else if (st_valid && (op_r == OP_DELETE) && (st_addr != idx_a)) begin
          mem_we    = 1'b1;
          mem_waddr = st_addr - 1'b1;
          mem_wdata = mem_rdata;
        end
      end
      S_FIN: begin
        if (status_r == ST_OK) begin
          case (op_r)
            OP_INSERT: begin
              mem_we   = 1'b1;
              len_next = len + 1'b1;
            end
            OP_SET: begin
              mem_we = 1'b1;
            end
            OP_APPEND: begin
              mem_we    = 1'b1;
              mem_waddr = ADDR_W'(len);
              len_next  = len + 1'b1;
            end
            OP_DELETE: begin
              len_next = len - 1'b1;
            end
            OP_CLEAR: begin
              len_next = '0;
            end
            default: begin
              len_next = len;
            end
          endcase
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      len      <= '0;
      done     <= 1'b0;
      iss      <= 1'b0;
      st_valid <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FIN);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r   <= opcode_t'(opcode);
            idx_r  <= index;
            data_r <= data;
          end
        end
        S_DECIDE: begin
          status_r <= dec_status;
          value_r  <= '0;
          pos_r    <= '0;
          rd_ptr   <= dec_first;
          last_ptr <= dec_last;
          up       <= dec_up;
          iss      <= go_stream;
          st_valid <= 1'b0;
        end
        S_STREAM: begin
          st_valid <= iss;
          if (iss) begin
            st_addr <= rd_ptr;
            if (rd_ptr == last_ptr) begin
              iss <= 1'b0;
            end else begin
              rd_ptr <= up ? rd_ptr + 1'b1 : rd_ptr - 1'b1;
            end
          end
          if (st_valid) begin
            if ((op_r == OP_GET) || ((op_r == OP_DELETE) && (st_addr == idx_a))) begin
              value_r <= $signed(mem_rdata);
            end
            if (hit) begin
              status_r <= ST_OK;
              pos_r    <= st_addr;
            end
          end
        end
        S_FIN: begin
          len             <= len_next;
          iss             <= 1'b0;
          st_valid        <= 1'b0;
          result.status   <= status_r;
          result.value    <= value_r;
          result.position <= POS_W'(pos_r);
          result.count    <= COUNT_W'(len_next);
        end
        default: begin
          iss <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- sv/array_list_engine_unit.sv -----
// Top level of the array list engine: capacity register, sequencer and entry store.
//
// The block keeps an ordered list of signed 32-bit words in a 64-entry store
// together with a length count. A request is an item of opcode, index and data;
// it is taken at a rising edge where start is high and busy is low. busy stays
// high until the item's work is finished, and no new item is taken meanwhile.
// Every item yields exactly one result: status, value, position and count,
// shown for one cycle with done high. The receiver cannot hold results off.
// Set, append, clear, checks that fail, insert at the list end and find on an
// empty list go from the decide state straight to the finish state.
// Get, delete, find and insert walk the store one entry per cycle through its
// single read port, and the next entry move rides on the write port in the same
// cycle. The entries walked are 1 for get, length - index for delete and
// insert, and up to the first match for find. busy is already low while done
// is shown, so the next item can be taken at the edge that ends that cycle.
// The capacity register is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle, as the block does not enforce
// this. It resets to 64. Reset empties the list (the length goes to zero)
// and leaves the store contents alone, since no entry past the length is read.
`timescale 1ns / 1ps

module array_list_engine_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [alist_pkg::OP_W-1:0]           opcode,
  input  logic [alist_pkg::INDEX_W-1:0]        index,
  input  logic signed [alist_pkg::DATA_W-1:0]  data,
  output logic                                 busy,
  output logic                                 done,
  output logic [alist_pkg::STATUS_W-1:0]       status,
  output logic signed [alist_pkg::DATA_W-1:0]  value,
  output logic [alist_pkg::POS_W-1:0]          position,
  output logic [alist_pkg::COUNT_W-1:0]        count,
  input  logic                                 cfg_we,
  input  logic [alist_pkg::CFG_W-1:0]          cfg_wdata
);

  import alist_pkg::*;

  logic [CFG_W-1:0]  max_length;
  logic [LEN_W-1:0]  capacity;
  result_t           res;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= CFG_RESET;
    end else if (cfg_we) begin
      max_length <= cfg_wdata;
    end
  end

  // The capacity in force is the register limited to the store size.
  assign capacity = (CAP_W'(max_length) < CAP_W'(DEPTH)) ? LEN_W'(max_length)
                                                         : LEN_W'(DEPTH);

  alist_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .index     (index),
    .data      (data),
    .capacity  (capacity),
    .busy      (busy),
    .done      (done),
    .result    (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  alist_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign status   = res.status;
  assign value    = res.value;
  assign position = res.position;
  assign count    = res.count;

  // A result only follows a cycle in which an item was being worked on.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an item in progress");

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // The reported length never exceeds the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (int'(count) <= DEPTH))
    else $error("reported length beyond store size");

  // A failed search reports neither a position nor a value.
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_NOTFOUND)) |-> ((position == '0) && (value == '0)))
    else $error("failed search reported a position or value");

endmodule

// ----- tb/sv/alist_result_checker.sv -----
// Result checker for the array list engine: mirrors the list and compares every result.
`timescale 1ns / 1ps

module alist_result_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [alist_pkg::OP_W-1:0]           opcode,
  input  logic [alist_pkg::INDEX_W-1:0]        index,
  input  logic signed [alist_pkg::DATA_W-1:0]  data,
  input  logic                                 done,
  input  logic [alist_pkg::STATUS_W-1:0]       status,
  input  logic signed [alist_pkg::DATA_W-1:0]  value,
  input  logic [alist_pkg::POS_W-1:0]          position,
  input  logic [alist_pkg::COUNT_W-1:0]        count,
  input  logic                                 cfg_we,
  input  logic [alist_pkg::CFG_W-1:0]          cfg_wdata,
  output int                                   failures,
  output int                                   pending,
  output logic [alist_pkg::LEN_W-1:0]          list_len
);

  import alist_pkg::*;

  // Mirror of the list: stored words, length and the capacity register.
  logic signed [DATA_W-1:0] mirror_slots [DEPTH];
  int                       mirror_len;
  logic [CFG_W-1:0]         mirror_cap;

  result_t awaited_results [$];
  result_t want;

  // Applies one request to the mirror and returns the result it must produce.
  function automatic result_t apply_request(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                                            logic signed [DATA_W-1:0] word);
    result_t r;
    int      room;
    int      at;
    int      k;
    r.status   = ST_OK;
    r.value    = '0;
    r.position = '0;
    room = (int'(mirror_cap) < DEPTH) ? int'(mirror_cap) : DEPTH;
    at   = int'(idx);
    case (op)
      OP_INSERT: begin
        if (at > mirror_len) begin
          r.status = ST_RANGE;
        end else if (mirror_len >= room) begin
          r.status = ST_FULL;
        end else begin
          for (k = mirror_len; k > at; k--) mirror_slots[k] = mirror_slots[k-1];
          mirror_slots[at] = word;
          mirror_len++;
        end
      end
      OP_DELETE: begin
        if (at >= mirror_len) begin
          r.status = ST_RANGE;
        end else begin
          r.value = mirror_slots[at];
          for (k = at; k + 1 < mirror_len; k++) mirror_slots[k] = mirror_slots[k+1];
          mirror_len--;
        end
      end
      OP_SET: begin
        if (at >= mirror_len) r.status = ST_RANGE;
        else mirror_slots[at] = word;
      end
      OP_GET: begin
        if (at >= mirror_len) r.status = ST_RANGE;
        else r.value = mirror_slots[at];
      end
      OP_FIND: begin
        r.status = ST_NOTFOUND;
        for (k = 0; k < mirror_len; k++) begin
          if (mirror_slots[k] == word) begin
            r.status   = ST_OK;
            r.position = POS_W'(k);
            break;
          end
        end
      end
      OP_APPEND: begin
        if (mirror_len >= room) begin
          r.status = ST_FULL;
        end else begin
          mirror_slots[mirror_len] = word;
          mirror_len++;
        end
      end
      OP_CLEAR: begin
        mirror_len = 0;
      end
      default: ;
    endcase
    r.count = COUNT_W'(mirror_len);
    return r;
  endfunction

  initial begin
    failures   = 0;
    mirror_len = 0;
    mirror_cap = CFG_RESET;
  end

  always @(posedge clk) begin
    if (rst) begin
      mirror_len = 0;
      mirror_cap = CFG_RESET;
      awaited_results.delete();
    end else begin
      // A result leaves before a request taken at the same edge joins the queue.
      if (done) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d value %0d position %0d count %0d",
                 status, value, position, count);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            failures++;
          end
          if (value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value);
            failures++;
          end
          if (position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, position);
            failures++;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count);
            failures++;
          end
        end
      end
      if (start && !busy) awaited_results.push_back(apply_request(opcode, index, data));
      if (cfg_we) mirror_cap = cfg_wdata;
    end
    pending  <= awaited_results.size();
    list_len <= LEN_W'(mirror_len);
  end

endmodule

// ----- tb/sv/array_list_engine_unit_test.sv -----
// Testbench top for the array list engine: stimulus, capacity phases and the verdict.
`timescale 1ns / 1ps

module array_list_engine_unit_test;
  import alist_pkg::*;

  // The eighth opcode is not an operation; the block must leave the list alone.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  // Worst correct run is roughly 900 items, each at most a full-list walk, plus
  // sender gaps; the limit leaves a wide margin on top of that.
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 10;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic [OP_W-1:0]           opcode;
  logic [INDEX_W-1:0]        index;
  logic signed [DATA_W-1:0]  data;
  logic                      busy;
  logic                      done;
  logic [STATUS_W-1:0]       status;
  logic signed [DATA_W-1:0]  value;
  logic [POS_W-1:0]          position;
  logic [COUNT_W-1:0]        count;
  logic                      cfg_we;
  logic [CFG_W-1:0]          cfg_wdata;

  int                        failures;
  int                        pending;
  logic [LEN_W-1:0]          list_len;
  int                        cycles;
  int                        burst_left;

  // Each random phase runs under one capacity setting with its own operation mix.
  // The capacities cover the extremes (0, 1, 64, 127) and settings that fall
  // below a list already built up, so insert and append must report full while
  // the stored entries stay readable.
  int   phase_cap   [PHASES] = '{64, 32, 127, 1, 0, 8, 3, 64, 50, 16};
  mix_t phase_mix   [PHASES] = '{MIX_GROW, MIX_EVEN, MIX_GROW, MIX_EVEN, MIX_EVEN,
                                 MIX_SHRINK, MIX_EVEN, MIX_EVEN, MIX_SHRINK, MIX_EVEN};
  int   phase_items [PHASES] = '{110, 90, 90, 60, 40, 90, 80, 130, 100, 60};
  bit   phase_gaps  [PHASES] = '{1, 1, 1, 1, 1, 0, 1, 0, 1, 1};

  array_list_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .index     (index),
    .data      (data),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .value     (value),
    .position  (position),
    .count     (count),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  alist_result_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .index     (index),
    .data      (data),
    .done      (done),
    .status    (status),
    .value     (value),
    .position  (position),
    .count     (count),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .pending   (pending),
    .list_len  (list_len)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("array_list_engine_unit verification failed");
    $finish;
  end

  // Presents one item at the falling edge and holds it until a rising edge
  // finds busy low. busy is read right after the edge, so it is the value
  // the block saw when it decided to take the item. start is left high so a
  // following item can go out back to back.
  task automatic issue_request(logic [OP_W-1:0] op, logic [INDEX_W-1:0] pos,
                               logic signed [DATA_W-1:0] word);
    @(negedge clk);
    start  <= 1'b1;
    opcode <= op;
    index  <= pos;
    data   <= word;
    do @(posedge clk); while (busy);
  endtask

  // Drops start for a number of cycles; the idle fields carry junk that the
  // block must ignore.
  task automatic pause_sender(int gap);
    @(negedge clk);
    start  <= 1'b0;
    opcode <= OP_W'($urandom);
    index  <= INDEX_W'($urandom);
    data   <= DATA_W'($urandom);
    repeat (gap - 1) @(negedge clk);
  endtask

  // Holds the sender off until every predicted result has come back and the
  // block has gone idle.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  // The capacity register may only change while nothing is in flight.
  task automatic write_capacity(int cap);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(cap);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Operation mix per phase: growing phases fill the list to its capacity,
  // shrinking phases drain it, so both full and empty corners are hit often.
  function automatic logic [OP_W-1:0] pick_opcode(mix_t mix);
    int r;
    int w_ins, w_app, w_del, w_get, w_set, w_find, w_clr;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   begin w_ins = 30; w_app = 30; w_del = 8;  w_get = 10; w_set = 8;
                        w_find = 10; w_clr = 1; end
      MIX_SHRINK: begin w_ins = 8;  w_app = 7;  w_del = 40; w_get = 15; w_set = 10;
                        w_find = 15; w_clr = 2; end
      default:    begin w_ins = 20; w_app = 18; w_del = 20; w_get = 14; w_set = 10;
                        w_find = 12; w_clr = 3; end
    endcase
    if (r < w_ins) return OP_INSERT;
    r -= w_ins;
    if (r < w_app) return OP_APPEND;
    r -= w_app;
    if (r < w_del) return OP_DELETE;
    r -= w_del;
    if (r < w_get) return OP_GET;
    r -= w_get;
    if (r < w_set) return OP_SET;
    r -= w_set;
    if (r < w_find) return OP_FIND;
    r -= w_find;
    if (r < w_clr) return OP_CLEAR;
    return OP_UNUSED;
  endfunction

  // Positions mostly land inside the list; the rest sit just past its end or
  // anywhere in the 8-bit range, to exercise the range checks.
  function automatic logic [INDEX_W-1:0] pick_index(logic [OP_W-1:0] op, int len);
    int r;
    int top;
    int v;
    r = $urandom_range(0, 99);
    case (op)
      OP_INSERT:                  top = len;
      OP_DELETE, OP_SET, OP_GET:  top = len - 1;
      default:                    return INDEX_W'($urandom_range(0, 255));
    endcase
    if (r < 80) begin
      v = (top < 0) ? 0 : $urandom_range(0, top);
    end else if (r < 92) begin
      v = len + $urandom_range(0, 3);
      if (v > 255) v = 255;
    end else begin
      v = $urandom_range(0, 255);
    end
    return INDEX_W'(v);
  endfunction

  // A small pool of repeated words makes find hit often, and duplicates make
  // sure the first match is the one reported.
  function automatic logic signed [DATA_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return DATA_W'($urandom_range(0, 9)) - 32'sd5;
    if (r < 45) return 32'sh8000_0000;
    if (r < 50) return 32'sh7fff_ffff;
    return DATA_W'($urandom);
  endfunction

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    opcode     = '0;
    index      = '0;
    data       = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, capacity at its full size of 64.
    write_capacity(64);
    // Every access to an empty list is out of range; find finds nothing.
    issue_request(OP_GET,    8'd0,   32'sd0);
    issue_request(OP_DELETE, 8'd0,   32'sd0);
    issue_request(OP_SET,    8'd0,   32'sd1);
    issue_request(OP_FIND,   8'd0,   32'sd5);
    issue_request(OP_INSERT, 8'd1,   32'sd3);
    issue_request(OP_UNUSED, 8'd0,   32'sd0);
    // Build [min, 0x55555555, max, 0, -1, 0xAAAAAAAA]: prepend, append, a
    // middle insert and an insert at the very end of the list.
    issue_request(OP_INSERT, 8'd0,   32'sh8000_0000);
    issue_request(OP_APPEND, 8'd0,   32'sh7fff_ffff);
    issue_request(OP_APPEND, 8'd255, 32'sd0);
    issue_request(OP_APPEND, 8'd0,   -32'sd1);
    issue_request(OP_INSERT, 8'd1,   32'sh5555_5555);
    issue_request(OP_INSERT, 8'd5,   32'shAAAA_AAAA);
    // Reads at both ends, then one at the length and one at the top index.
    issue_request(OP_GET,    8'd0,   32'sd0);
    issue_request(OP_GET,    8'd5,   32'sd0);
    issue_request(OP_GET,    8'd6,   32'sd0);
    issue_request(OP_GET,    8'd255, 32'sd0);
    issue_request(OP_SET,    8'd2,   32'sd7);
    // A duplicate of -1 at the end: find must still report the first one.
    issue_request(OP_APPEND, 8'd0,   -32'sd1);
    issue_request(OP_FIND,   8'd0,   -32'sd1);
    issue_request(OP_FIND,   8'd0,   32'sd12345);
    // Delete at the front, at the last entry and in the middle.
    issue_request(OP_DELETE, 8'd0,   32'sd0);
    issue_request(OP_DELETE, 8'd5,   32'sd0);
    issue_request(OP_DELETE, 8'd2,   32'sd0);
    issue_request(OP_INSERT, 8'd255, 32'sd9);
    issue_request(OP_CLEAR,  8'd0,   32'sd0);
    issue_request(OP_GET,    8'd0,   32'sd0);

    // Capacity of one: the second word is refused, and an insert past the end
    // reports the range error ahead of the full condition.
    write_capacity(1);
    issue_request(OP_APPEND, 8'd0,   32'sd9);
    issue_request(OP_APPEND, 8'd0,   32'sd10);
    issue_request(OP_INSERT, 8'd0,   32'sd11);
    issue_request(OP_INSERT, 8'd3,   32'sd12);

    // Capacity of zero: the list is always full.
    write_capacity(0);
    issue_request(OP_INSERT, 8'd0,   32'sd13);
    issue_request(OP_CLEAR,  8'd0,   32'sd0);
    issue_request(OP_APPEND, 8'd0,   32'sd14);

    // Random phases. Each starts by draining the block and rewriting the
    // capacity, which also gives the pause-until-empty pressure on the sender.
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      for (int n = 0; n < phase_items[p]; n++) begin
        logic [OP_W-1:0] op;
        op = pick_opcode(phase_mix[p]);
        issue_request(op, pick_index(op, int'(list_len)), pick_word());
        // Bursts of back-to-back items separated by gaps of random length;
        // some phases run with no gaps at all.
        if (phase_gaps[p]) begin
          if (burst_left == 0) begin
            pause_sender($urandom_range(1, 14));
            burst_left = $urandom_range(1, 24);
          end else begin
            burst_left--;
          end
        end
      end
    end

    // Wait out every outstanding result, then a margin longer than the
    // slowest item, so a stray extra result is still caught.
    settle();
    repeat (80) @(posedge clk);
    if (failures == 0) begin
      $display("array_list_engine_unit verification clean");
    end else begin
      $display("array_list_engine_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/alist_pkg.sv
sv/alist_ram.sv
sv/alist_seq.sv
sv/array_list_engine_unit.sv
tb/sv/alist_result_checker.sv
tb/sv/array_list_engine_unit_test.sv
